@@ design/vdg_pkg.sv @@
// shared types, colour codes and helper functions for the vdg dot row generator
`default_nettype none
package vdg_pkg;

  // palette indices
  localparam logic [3:0] COL_BLACK       = 4'd0;
  localparam logic [3:0] COL_GREEN       = 4'd1;
  localparam logic [3:0] COL_YELLOW      = 4'd2;
  localparam logic [3:0] COL_BLUE        = 4'd3;
  localparam logic [3:0] COL_RED         = 4'd4;
  localparam logic [3:0] COL_BUFF        = 4'd5;
  localparam logic [3:0] COL_CYAN        = 4'd6;
  localparam logic [3:0] COL_MAGENTA     = 4'd7;
  localparam logic [3:0] COL_ORANGE      = 4'd8;
  localparam logic [3:0] COL_CYAN_BLUE   = 4'd9;
  localparam logic [3:0] COL_LIGHT_GREEN = 4'd10;
  localparam logic [3:0] COL_DARK_GREEN  = 4'd11;

  // color_mode register codes
  localparam logic [1:0] CMODE_OLD    = 2'd0;
  localparam logic [1:0] CMODE_NEW1   = 2'd1;
  localparam logic [1:0] CMODE_NEW2   = 2'd2;
  localparam logic [1:0] CMODE_GREEN  = 2'd3;
  localparam logic [1:0] CMODE_RESET  = CMODE_NEW2;

  // graphics modes, stored as mode minus two
  localparam logic [1:0] GMODE_MID_A = 2'd0;
  localparam logic [1:0] GMODE_MID_B = 2'd1;
  localparam logic [1:0] GMODE_HI_A  = 2'd2;
  localparam logic [1:0] GMODE_HI_B  = 2'd3;
  localparam logic [7:0] GMODE_MASK  = 8'h8e;

  // font sources
  localparam logic [1:0] FSRC_FONT = 2'd0;
  localparam logic [1:0] FSRC_SYS  = 2'd1;
  localparam logic [1:0] FSRC_SEMI = 2'd2;

  // register indexes
  localparam logic REG_COLOR_MODE    = 1'b0;
  localparam logic REG_GRAPHICS_MODE = 1'b1;

  localparam logic [12:0] GFX_LIMIT     = 13'd6144;
  localparam logic [12:0] SYS_BASE_HI   = 13'h1600;
  localparam logic [12:0] SYS_BASE_LO   = 13'h1000;

  typedef struct packed {
    logic        op;
    logic [12:0] position;
    logic [7:0]  data_byte;
    logic [7:0]  attr_byte;
    logic [3:0]  cell_row;
    logic [7:0]  font_byte;
  } vdg_in_t;

  typedef struct packed {
    logic        in_range;
    logic [7:0]  dot_x;
    logic [7:0]  dot_y;
    logic [1:0]  font_source;
    logic [12:0] font_address;
    logic [31:0] dot_colors;
    logic        double_line;
  } vdg_out_t;

  // one nibble per dot, msb of bits leftmost
  function automatic logic [31:0] spread(logic [7:0] bits, logic [3:0] fg, logic [3:0] bg);
    logic [31:0] r;
    r = '0;
    for (int j = 0; j < 8; j++) begin
      r[31 - 4*j -: 4] = bits[7 - j] ? fg : bg;
    end
    return r;
  endfunction

  function automatic logic [3:0] gfx_color(logic [1:0] gmode, logic [1:0] idx,
                                           logic [1:0] cmode);
    logic [3:0] c;
    case (gmode)
      GMODE_MID_A: begin
        case (idx)
          2'd0:    c = COL_GREEN;
          2'd1:    c = COL_YELLOW;
          2'd2:    c = COL_BLUE;
          default: c = COL_RED;
        endcase
      end
      GMODE_MID_B: begin
        case (idx)
          2'd0:    c = COL_BLUE;
          2'd1:    c = COL_CYAN_BLUE;
          2'd2:    c = COL_MAGENTA;
          default: c = COL_ORANGE;
        endcase
      end
      GMODE_HI_A: c = idx[0] ? COL_GREEN : COL_BLACK;
      default:    c = idx[0] ? COL_LIGHT_GREEN : COL_BLACK;
    endcase
    if (gmode == GMODE_MID_A && idx == 2'd0 && cmode == CMODE_GREEN) c = COL_DARK_GREEN;
    if (gmode == GMODE_HI_B && idx[0] && cmode == CMODE_OLD) c = COL_CYAN;
    return c;
  endfunction

endpackage
`default_nettype wire

@@ design/vdg_text_row.sv @@
// text cell row: font source and address, colour pair, semigraphic blocks
`default_nettype none
module vdg_text_row (
  input  var vdg_pkg::vdg_in_t  item_i,
  input  wire logic [1:0]       color_mode_i,
  output var vdg_pkg::vdg_out_t res_o
);

  logic [8:0]  cell_idx;
  logic [8:0]  y_sum;
  logic [7:0]  code;
  logic [7:0]  attr;
  logic [3:0]  row;
  logic [5:0]  pat;
  logic [7:0]  bits;
  logic [3:0]  fg_semi;
  logic [3:0]  p2, p3, fg, bg;
  logic [7:0]  code_m;
  logic [7:0]  off_hi, off_lo, off_font;
  logic [12:0] addr_semi;

  assign cell_idx = item_i.position[8:0];
  assign code = item_i.data_byte;
  assign attr = item_i.attr_byte;
  assign row  = item_i.cell_row;
  assign y_sum = {5'b0, cell_idx[8:5]} * 9'd12 + {5'b0, row};

  // semigraphic blocks
  always_comb begin
    bits = 8'h00;
    if (!attr[3]) begin
      pat     = {2'b00, code[3:0]};
      fg_semi = {1'b0, code[6:4]} + 4'd1;
      if (row < 4'd6) begin
        bits = {{4{pat[3]}}, {4{pat[2]}}};
      end else begin
        bits = {{4{pat[1]}}, {4{pat[0]}}};
      end
    end else begin
      pat     = code[5:0];
      fg_semi = {1'b0, attr[1], code[7:6]} + 4'd1;
      if (row < 4'd4) begin
        bits = {{4{pat[5]}}, {4{pat[4]}}};
      end else if (row < 4'd8) begin
        bits = {{4{pat[3]}}, {4{pat[2]}}};
      end else begin
        bits = {{4{pat[1]}}, {4{pat[0]}}};
      end
    end
  end

  assign addr_semi = {7'b0, pat} * 13'd12 + {9'b0, row};

  // colour pair for font text
  always_comb begin
    p2 = vdg_pkg::COL_BUFF;
    p3 = vdg_pkg::COL_ORANGE;
    if (color_mode_i == vdg_pkg::CMODE_OLD) begin
      p2 = vdg_pkg::COL_BLACK;
      p3 = vdg_pkg::COL_CYAN;
    end else if (color_mode_i == vdg_pkg::CMODE_NEW1) begin
      p2 = vdg_pkg::COL_BLACK;
      p3 = vdg_pkg::COL_ORANGE;
    end
    case (attr[1:0])
      2'd0: begin fg = vdg_pkg::COL_GREEN; bg = vdg_pkg::COL_BLACK; end
      2'd1: begin fg = vdg_pkg::COL_BLACK; bg = vdg_pkg::COL_GREEN; end
      2'd2: begin fg = p3; bg = p2; end
      default: begin fg = p2; bg = p3; end
    endcase
  end

  // character code remap
  always_comb begin
    code_m = code;
    if (code < 8'd32 && !attr[3]) code_m = 8'd32;
    if (attr[3] && code < 8'd96) code_m = code + 8'd128;
  end

  assign off_hi   = code_m - 8'd96;
  assign off_lo   = code_m - 8'd128;
  assign off_font = code_m - 8'd32;

  always_comb begin
    res_o             = '0;
    res_o.in_range    = 1'b1;
    res_o.dot_x       = {cell_idx[4:0], 3'b000};
    res_o.dot_y       = y_sum[7:0];
    res_o.double_line = 1'b0;
    if (attr[2]) begin
      res_o.font_source  = vdg_pkg::FSRC_SEMI;
      res_o.font_address = addr_semi;
      res_o.dot_colors   = vdg_pkg::spread(bits, fg_semi, vdg_pkg::COL_BLACK);
    end else begin
      res_o.dot_colors = vdg_pkg::spread(item_i.font_byte, fg, bg);
      if (code_m inside {[8'd96:8'd127]}) begin
        res_o.font_source  = vdg_pkg::FSRC_SYS;
        res_o.font_address = vdg_pkg::SYS_BASE_HI + 13'({off_hi[4:0], 4'b0000})
                             + {9'b0, row};
      end else if (code_m inside {[8'd128:8'd223]}) begin
        res_o.font_source  = vdg_pkg::FSRC_SYS;
        res_o.font_address = vdg_pkg::SYS_BASE_LO + 13'({off_lo[6:0], 4'b0000})
                             + {9'b0, row};
      end else begin
        res_o.font_source  = vdg_pkg::FSRC_FONT;
        res_o.font_address = {5'b0, off_font} * 13'd12 + {9'b0, row};
      end
    end
  end

endmodule
`default_nettype wire

@@ design/vdg_gfx_row.sv @@
// graphics byte: mode decode and mid-res / hi-res dot colours
`default_nettype none
module vdg_gfx_row (
  input  wire logic [12:0]      position_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic [7:0]       graphics_mode_i,
  input  wire logic [1:0]       color_mode_i,
  output var vdg_pkg::vdg_out_t res_o
);

  logic [7:0]  gm_masked;
  logic [1:0]  gmode;
  logic [31:0] mid_dots;
  logic [3:0]  c;

  assign gm_masked = graphics_mode_i & vdg_pkg::GMODE_MASK;

  always_comb begin
    case (gm_masked)
      8'h80, 8'h0a, 8'h0c: gmode = vdg_pkg::GMODE_MID_A;
      8'h8a, 8'h8c:        gmode = vdg_pkg::GMODE_MID_B;
      8'h0e:               gmode = vdg_pkg::GMODE_HI_A;
      default:             gmode = vdg_pkg::GMODE_HI_B;
    endcase
  end

  // four 2-bit pixels, each two dots wide
  always_comb begin
    mid_dots = '0;
    for (int k = 0; k < 4; k++) begin
      c = vdg_pkg::gfx_color(gmode, data_byte_i[7 - 2*k -: 2], color_mode_i);
      mid_dots[31 - 8*k -: 8] = {c, c};
    end
  end

  always_comb begin
    res_o = '0;
    if (position_i < vdg_pkg::GFX_LIMIT) begin
      res_o.in_range = 1'b1;
      res_o.dot_x    = {position_i[4:0], 3'b000};
      res_o.dot_y    = position_i[12:5];
      if (!gmode[1]) begin
        res_o.double_line = 1'b1;
        res_o.dot_colors  = mid_dots;
      end else begin
        res_o.dot_colors = vdg_pkg::spread(data_byte_i,
                             vdg_pkg::gfx_color(gmode, 2'd1, color_mode_i),
                             vdg_pkg::gfx_color(gmode, 2'd0, color_mode_i));
      end
    end
  end

endmodule
`default_nettype wire

@@ design/vdg_pixel_row_generator.sv @@
// Usage: one input word (a text cell row or a graphics byte) gives one result word
// holding eight double-width dots as palette indices plus position and font fetch
// info. Both channels use valid/stall; a word moves on a rising edge with valid high
// and stall low. The input word is captured in an input register, the dot row is
// built combinationally by the text or graphics path and lands in the output
// register, which drives out_valid_o. Throughput is one word per cycle while the
// output is not stalled, set by the single pass from input register to output
// register. While out_stall_i holds the output register, the input register still
// takes one more word; only when both are full does in_stall_o rise. The APB port
// writes color_mode (address 0) and graphics_mode (address 4); writes are expected
// only while no word is in flight. Reset empties both registers and sets color_mode
// to 2 and graphics_mode to 0.
`default_nettype none
module vdg_pixel_row_generator (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output wire logic              in_stall_o,
  input  var vdg_pkg::vdg_in_t   in_data_i,
  output wire logic              out_valid_o,
  input  wire logic              out_stall_i,
  output var vdg_pkg::vdg_out_t  out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output wire logic              pready
);

  logic              color_wr, gfx_wr;
  logic [1:0]        color_mode_q;
  logic [7:0]        graphics_mode_q;
  logic              s1_valid_q, s1_valid_d;
  vdg_pkg::vdg_in_t  s1_data_q;
  logic              s2_valid_q, s2_valid_d;
  vdg_pkg::vdg_out_t s2_data_q;
  logic              s2_load, in_acc;
  vdg_pkg::vdg_out_t text_res, gfx_res;

  assign pready   = 1'b1;
  assign color_wr = psel && penable && pwrite && pready && paddr[2] == vdg_pkg::REG_COLOR_MODE;
  assign gfx_wr   = psel && penable && pwrite && pready
                    && paddr[2] == vdg_pkg::REG_GRAPHICS_MODE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q    <= vdg_pkg::CMODE_RESET;
      graphics_mode_q <= 8'h00;
    end else begin
      if (color_wr) color_mode_q <= pwdata[1:0];
      if (gfx_wr) graphics_mode_q <= pwdata[7:0];
    end
  end

  always_comb begin
    if (paddr[2] == vdg_pkg::REG_COLOR_MODE) begin
      prdata = {30'b0, color_mode_q};
    end else begin
      prdata = {24'b0, graphics_mode_q};
    end
  end

  // pipeline control
  assign s2_load    = !s2_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s2_load) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s2_load) s2_valid_d = s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) s1_data_q <= in_data_i;
    if (s2_load && s1_valid_q) s2_data_q <= s1_data_q.op ? text_res : gfx_res;
  end

  vdg_text_row u_text (
    .item_i       (s1_data_q),
    .color_mode_i (color_mode_q),
    .res_o        (text_res)
  );

  vdg_gfx_row u_gfx (
    .position_i      (s1_data_q.position),
    .data_byte_i     (s1_data_q.data_byte),
    .graphics_mode_i (graphics_mode_q),
    .color_mode_i    (color_mode_q),
    .res_o           (gfx_res)
  );

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

endmodule
`default_nettype wire

@@ design/vdg_checker.sv @@
// port-level checks for the vdg dot row generator, bound to the top level
`default_nettype none
module vdg_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input var vdg_pkg::vdg_out_t  out_data_o
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // input only backs up when the output register is full and held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output");

  // out-of-range graphics words carry nothing else
  a_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.in_range |->
      out_data_o.dot_colors == 32'h0 && out_data_o.font_address == 13'h0
      && out_data_o.dot_x == 8'h0 && out_data_o.dot_y == 8'h0
      && !out_data_o.double_line)
    else $error("out-of-range word has nonzero fields");

  // mid-res rows come only from graphics words
  a_double_gfx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.double_line |->
      out_data_o.in_range && out_data_o.font_source == vdg_pkg::FSRC_FONT
      && out_data_o.font_address == 13'h0)
    else $error("double line set on a text word");

endmodule

bind vdg_pixel_row_generator vdg_checker u_vdg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
